@@ rtl/core/ase_pkg.sv @@
// Shared types and constants for the array search engine.
`timescale 1ns / 1ps
`default_nettype none
package ase_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned POS_W           = 10;
    localparam int unsigned COUNT_W         = 11;

    // Input operation codes
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // search_mode register values
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_SEARCH_MODE   = 1'b0;
    localparam t_cfg_index CFG_ELEMENT_COUNT = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [POS_W-1:0]         store_position;
        logic signed [DATA_W-1:0] element_value;
        logic signed [DATA_W-1:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] found_position;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CHECK = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

endpackage
`default_nettype wire

@@ rtl/core/ase_table.sv @@
// Element table: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ase_table #(
    parameter int unsigned DEPTH = ase_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_wr_en,
    input  wire logic [AW-1:0]                     i_wr_addr,
    input  wire logic signed [ase_pkg::DATA_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]                     i_rd_addr,
    output logic signed [ase_pkg::DATA_W-1:0]      o_rd_data
);

    logic signed [ase_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

@@ rtl/core/array_search_engine.sv @@
// Array search engine top level: table store plus linear/binary search sequencer.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): a store transaction writes
// element_value at store_position (ignored at or above TABLE_DEPTH) and gives no
// result; stores are taken one per cycle while no search is in flight. A search
// transaction compares search_key against the first element_count entries and
// gives one result on the output channel (o_out_valid / i_out_stall / o_out_data).
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 = search_mode,
// index 1 = element_count; write only while no search is in flight.
// Search: the table has one read port with registered data. Linear search reads one
// entry per cycle, scanning up to TABLE_DEPTH entries. Binary search takes each
// probe through PROBE (address) and CHECK (compare); a zero count reads no entry.
// o_in_stall stays high from a search transaction until its result is loaded
// into the output register; the next search can then start while that result
// waits. If the receiver stalls, the result holds and a finished search waits.
// Reset (synchronous, active low) clears the sequencer, output valid and both
// registers; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module array_search_engine #(
    parameter int unsigned TABLE_DEPTH = ase_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire ase_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output ase_pkg::t_out_item                    o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire ase_pkg::t_cfg_index              i_cfg_index,
    input  wire logic [ase_pkg::COUNT_W-1:0]      i_cfg_data
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CW = (NW > ase_pkg::COUNT_W) ? NW : ase_pkg::COUNT_W;
    localparam logic [CW-1:0] DEPTH_CW = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_CW   = CW'(1);

    ase_pkg::t_state r_state, n_state;

    logic                                   r_search_mode;
    logic [ase_pkg::COUNT_W-1:0]            r_element_count;
    logic signed [ase_pkg::DATA_W-1:0]      r_key, n_key;
    logic [CW-1:0]                          r_idx, n_idx;
    logic [CW-1:0]                          r_lo, n_lo;
    logic [CW-1:0]                          r_he, n_he;
    logic [CW-1:0]                          r_cnt, n_cnt;
    ase_pkg::t_out_item                     r_res, n_res;
    logic                                   r_out_valid, n_out_valid;
    ase_pkg::t_out_item                     r_out_data, n_out_data;

    logic                                   in_accept;
    logic [CW-1:0]                          cnt_ext;
    logic [CW-1:0]                          cnt_lim;
    logic [CW-1:0]                          pos_ext;
    logic [CW-1:0]                          mid;
    logic [CW-1:0]                          idx_nx;
    logic                                   wr_en;
    logic [AW-1:0]                          rd_addr;
    logic signed [ase_pkg::DATA_W-1:0]      rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ase_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_accept = i_in_valid && (r_state == ase_pkg::S_IDLE);
    assign cnt_ext   = CW'(r_element_count);
    assign cnt_lim   = (cnt_ext > DEPTH_CW) ? DEPTH_CW : cnt_ext;
    assign pos_ext   = CW'(i_in_data.store_position);
    assign wr_en     = in_accept && (i_in_data.operation == ase_pkg::OP_STORE)
                       && (pos_ext < DEPTH_CW);
    // Half-open window [lo, he): same midpoint as lo + (hi - lo) / 2 with hi = he - 1
    assign mid       = r_lo + ((r_he - r_lo - ONE_CW) >> 1);
    assign idx_nx    = r_idx + ONE_CW;

    ase_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (pos_ext[AW-1:0]),
        .i_wr_data (i_in_data.element_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_he        = r_he;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        rd_addr     = r_idx[AW-1:0];

        case (r_state)
            ase_pkg::S_IDLE: begin
                if (in_accept && (i_in_data.operation == ase_pkg::OP_SEARCH)) begin
                    n_key = i_in_data.search_key;
                    n_cnt = cnt_lim;
                    n_idx = '0;
                    n_lo  = '0;
                    n_he  = cnt_lim;
                    if (cnt_lim == '0) begin
                        n_res   = '0;
                        n_state = ase_pkg::S_EMIT;
                    end else begin
                        n_state = ase_pkg::S_PROBE;
                    end
                end
            end
            ase_pkg::S_PROBE: begin
                if (r_search_mode == ase_pkg::MODE_BINARY) begin
                    if (r_lo >= r_he) begin
                        n_res   = '0;
                        n_state = ase_pkg::S_EMIT;
                    end else begin
                        n_idx   = mid;
                        rd_addr = mid[AW-1:0];
                        n_state = ase_pkg::S_CHECK;
                    end
                end else begin
                    n_state = ase_pkg::S_CHECK;
                end
            end
            ase_pkg::S_CHECK: begin
                if (rd_data == r_key) begin
                    n_res.found          = 1'b1;
                    n_res.found_position = r_idx[ase_pkg::POS_W-1:0];
                    n_state              = ase_pkg::S_EMIT;
                end else if (r_search_mode == ase_pkg::MODE_BINARY) begin
                    if (rd_data < r_key) begin
                        n_lo = idx_nx;
                    end else begin
                        n_he = r_idx;
                    end
                    n_state = ase_pkg::S_PROBE;
                end else if (idx_nx >= r_cnt) begin
                    n_res   = '0;
                    n_state = ase_pkg::S_EMIT;
                end else begin
                    // keep one read in flight: fetch the next entry while comparing this one
                    n_idx   = idx_nx;
                    rd_addr = idx_nx[AW-1:0];
                end
            end
            ase_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ase_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ase_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ase_pkg::S_IDLE;
            r_out_valid     <= 1'b0;
            r_search_mode   <= ase_pkg::MODE_LINEAR;
            r_element_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ase_pkg::CFG_SEARCH_MODE:   r_search_mode   <= i_cfg_data[0];
                    ase_pkg::CFG_ELEMENT_COUNT: r_element_count <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_lo       <= n_lo;
        r_he       <= n_he;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire

@@ rtl/core/ase_checker.sv @@
// Port-level checks for the array search engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ase_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire ase_pkg::t_in_item   i_in_data,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire ase_pkg::t_out_item  o_out_data
);

    // A result held by the receiver stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.found_position == '0)
        else $error("not-found result with nonzero position");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.operation == ase_pkg::OP_SEARCH)
        |=> o_in_stall)
        else $error("search transaction did not make the block busy");

    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.operation == ase_pkg::OP_STORE)
        |=> !o_in_stall)
        else $error("store transaction stalled the input");

endmodule

bind array_search_engine ase_checker u_ase_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire
